>>> hw/rtl/otc_pkg.sv
`default_nettype none
package otc_pkg;
    localparam int ATTR_COUNT = 16;
    localparam int ATTR_FRACTION_BITS = 15;
    localparam int ADDER_DEPTH = 4;
    localparam int NODE_COUNT = 256;
    localparam int MAX_DEPTH = 8;
    localparam int SLOTS = ATTR_COUNT + 1;
    localparam int SHIFT = ATTR_FRACTION_BITS + ADDER_DEPTH;
    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int ATTR_W = $clog2(ATTR_COUNT);
    localparam int WADDR_W = $clog2(NODE_COUNT * SLOTS);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int SUM_W = 32 + ATTR_W + 1;

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_LINKS = 2'd1;
    localparam logic [1:0] CMD_ATTR = 2'd2;
    localparam logic [1:0] CMD_CLASSIFY = 2'd3;

    typedef struct packed {
        logic [7:0] right_link;
        logic       right_is_leaf;
        logic [7:0] left_link;
        logic       left_is_leaf;
    } links_t;
endpackage
`default_nettype wire

>>> hw/rtl/oblique_tree_classifier.sv
// Oblique decision tree classifier.
// Input words arrive on s_axis (tdata carries cmd, node_index, slot_index,
// data_value, left_link, left_is_leaf, right_link, right_is_leaf). Weight,
// link and attribute writes can follow back to back while the block is idle
// and produce no output.
// A classify word walks the tree from node 0. Each level streams the node's
// weights and attributes out of the memories, one product per cycle into an
// accumulator, and a walk covers up to MAX_DEPTH levels. The weight memory has
// a single read port, so the weight and threshold reads are serialized. The
// result word (leaf_id, depth_error) is held in an output register until
// m_axis_tready; the block then accepts the next word in the following cycle.
// The user must write attributes_in_use over the cfg channel only while the
// block is idle; the block itself does not enforce this.
// Reset clears the state register and the read and product valid flags and
// sets attributes_in_use to 16; the memories hold nothing defined until
// written. A stalled receiver simply holds the result and the input side waits.
`default_nettype none
module oblique_tree_classifier
    import otc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd[1:0], node_index[9:2], slot_index[14:10], data_value[30:15],
    // left_link[38:31], left_is_leaf[39], right_link[47:40], right_is_leaf[48]
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // leaf_id[7:0], depth_error[8]
    output logic      [15:0] m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DOT = 2'd1;
    localparam logic [1:0] ST_DEC = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [1:0] cmd;
    logic [7:0] node_in;
    logic [4:0] slot_in;
    logic [15:0] data_in;
    links_t links_in;
    assign cmd = s_axis_tdata[1:0];
    assign node_in = s_axis_tdata[9:2];
    assign slot_in = s_axis_tdata[14:10];
    assign data_in = s_axis_tdata[30:15];
    assign links_in = {s_axis_tdata[47:40], s_axis_tdata[48],
                       s_axis_tdata[38:31], s_axis_tdata[39]};

    logic [1:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [4:0] aiu_reg;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [DEPTH_W-1:0] lvl_reg, lvl_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic signed [31:0] prod_reg;
    logic prod_v_reg;
    logic rd_v_reg;
    logic [7:0] leaf_reg, leaf_next;
    logic err_reg, err_next;

    logic [4:0] count;
    assign count = (aiu_reg > 5'(ATTR_COUNT)) ? 5'(ATTR_COUNT) : aiu_reg;

    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    // Weight memory: write on accepted weight words, read during the walk.
    logic w_we;
    logic [WADDR_W-1:0] w_waddr, w_raddr;
    logic [15:0] w_rdata;
    assign w_we = accept && cmd == CMD_WEIGHT && node_in < NODE_W'(NODE_COUNT - 1) + 1
                  && slot_in <= 5'(ATTR_COUNT);
    assign w_waddr = WADDR_W'(node_in * SLOTS + slot_in);
    assign w_raddr = WADDR_W'(node_reg * SLOTS + cnt_reg);
    otc_ram #(.WIDTH(16), .DEPTH(NODE_COUNT * SLOTS)) u_wram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(data_in),
        .raddr(w_raddr), .rdata(w_rdata));

    logic l_we;
    links_t l_rdata;
    assign l_we = accept && cmd == CMD_LINKS && 32'(node_in) < NODE_COUNT;
    otc_ram #(.WIDTH(18), .DEPTH(NODE_COUNT)) u_lram (
        .clk(clk), .we(l_we), .waddr(NODE_W'(node_in)), .wdata(links_in),
        .raddr(node_reg), .rdata(l_rdata));

    logic a_we;
    logic [15:0] a_rdata;
    assign a_we = accept && cmd == CMD_ATTR && 32'(slot_in) < ATTR_COUNT;
    otc_ram #(.WIDTH(16), .DEPTH(ATTR_COUNT)) u_aram (
        .clk(clk), .we(a_we), .waddr(ATTR_W'(slot_in)), .wdata(data_in),
        .raddr(ATTR_W'(cnt_reg)), .rdata(a_rdata));

    logic signed [SUM_W-1:0] shifted;
    logic signed [15:0] value;
    logic go_right;
    logic [7:0] link;
    logic leaf;
    assign shifted = acc_reg >>> SHIFT;
    assign value = shifted[15:0];
    assign go_right = value >= $signed(w_rdata);
    assign link = go_right ? l_rdata.right_link : l_rdata.left_link;
    assign leaf = go_right ? l_rdata.right_is_leaf : l_rdata.left_is_leaf;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        node_next = node_reg;
        lvl_next = lvl_reg;
        acc_next = acc_reg;
        leaf_next = leaf_reg;
        err_next = err_reg;
        if (prod_v_reg)
        begin
            acc_next = acc_reg + SUM_W'(prod_reg);
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd == CMD_CLASSIFY)
                begin
                    state_next = ST_DOT;
                    node_next = '0;
                    lvl_next = '0;
                    cnt_next = '0;
                    acc_next = '0;
                end
            end
            ST_DOT:
            begin
                // Issue reads for slots 0..count-1, then the threshold slot.
                if (cnt_reg >= count)
                begin
                    cnt_next = 5'(ATTR_COUNT);
                    if (!rd_v_reg && !prod_v_reg && cnt_reg == 5'(ATTR_COUNT))
                    begin
                        state_next = ST_DEC;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DEC:
            begin
                lvl_next = lvl_reg + DEPTH_W'(1);
                acc_next = '0;
                cnt_next = '0;
                if (leaf)
                begin
                    leaf_next = link;
                    err_next = 1'b0;
                    state_next = ST_OUT;
                end
                else if (32'(link) >= NODE_COUNT ||
                         32'(lvl_reg) + 1 >= MAX_DEPTH)
                begin
                    leaf_next = '0;
                    err_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    node_next = NODE_W'(link);
                    state_next = ST_DOT;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            aiu_reg <= 5'd16;
            prod_v_reg <= 1'b0;
            rd_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                aiu_reg <= cfg_data;
            end
            rd_v_reg <= (state_reg == ST_DOT) && cnt_reg < count;
            prod_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        node_reg <= node_next;
        lvl_reg <= lvl_next;
        acc_reg <= acc_next;
        leaf_reg <= leaf_next;
        err_reg <= err_next;
        prod_reg <= $signed(w_rdata) * $signed(a_rdata);
    end

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = {7'd0, err_reg, leaf_reg};

    a_err_no_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && err_reg |-> leaf_reg == 8'd0)
        else $error("error result carries a leaf id");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DEC |-> 32'(lvl_reg) < MAX_DEPTH)
        else $error("walk exceeded depth limit");
endmodule
`default_nettype wire

>>> hw/rtl/otc_ram.sv
`default_nettype none
module otc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
